FILE: src/occ_pkg.sv
// ----------------------------------------------------------------------------
// Occupancy counter package
// Shared types, state codes and result codes for the occupancy counter.
// ----------------------------------------------------------------------------
package occ_pkg;

   localparam logic [15:0] COUNT_MAX = 16'd255;
   localparam logic [7:0]  CAPACITY_RESET = 8'd255;

   localparam logic [3:0] SQ_IDLE      = 4'd0;
   localparam logic [3:0] SQ_IN_START  = 4'd1;
   localparam logic [3:0] SQ_IN_BOTH   = 4'd2;
   localparam logic [3:0] SQ_IN_INNER  = 4'd3;
   localparam logic [3:0] SQ_IN_DONE   = 4'd4;
   localparam logic [3:0] SQ_OUT_START = 4'd5;
   localparam logic [3:0] SQ_OUT_BOTH  = 4'd6;
   localparam logic [3:0] SQ_OUT_OUTER = 4'd7;
   localparam logic [3:0] SQ_OUT_DONE  = 4'd8;

   localparam logic [1:0] PASS_NONE  = 2'd0;
   localparam logic [1:0] PASS_ENTER = 2'd1;
   localparam logic [1:0] PASS_LEAVE = 2'd2;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_ENTRY_ORDER = 3'd1;
   localparam logic [2:0] ERR_EXIT_ORDER  = 3'd2;
   localparam logic [2:0] ERR_FULL        = 3'd3;
   localparam logic [2:0] ERR_EMPTY       = 3'd4;

   localparam logic [1:0] LOAD_NONE     = 2'd0;
   localparam logic [1:0] LOAD_FULL     = 2'd1;
   localparam logic [1:0] LOAD_NOT_FULL = 2'd2;

   typedef struct packed {
      logic outer_detect;
      logic inner_detect;
      logic restart;
   } occ_req_type;

   typedef struct packed {
      logic [7:0] occupancy;
      logic [1:0] pass_event;
      logic [2:0] error_code;
      logic [1:0] load_event;
      logic       entry_allowed;
   } occ_rsp_type;

endpackage

FILE: src/occ_in_stage.sv
// ----------------------------------------------------------------------------
// Occupancy counter input stage
// Registers one request transaction and holds it while the next stage waits.
// ----------------------------------------------------------------------------
module occ_in_stage
   import occ_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  occ_req_type req_data,
   output logic        stage_valid,
   output occ_req_type stage_data,
   input  logic        down_ready
);

   logic        valid_ff;
   occ_req_type data_ff;

   assign req_stall   = valid_ff && !down_ready;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         data_ff <= req_data;
      end
   end

endmodule

FILE: src/occ_tracker.sv
// ----------------------------------------------------------------------------
// Occupancy counter tracker
// Pass sequence state machine, person count, capacity register and full flag.
// ----------------------------------------------------------------------------
module occ_tracker
   import occ_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        step,
   input  occ_req_type sample,
   output occ_rsp_type result
);

   logic [3:0] seq_ff;
   logic [3:0] seq_in;
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic       full_ff;
   logic       full_in;
   logic [7:0] capacity_ff;
   logic [1:0] pass_ev;
   logic [2:0] err;
   logic [1:0] load_ev;
   logic       only_o;
   logic       only_i;
   logic       both;
   logic       none;
   logic       room_left;

   assign only_o    = sample.outer_detect && !sample.inner_detect;
   assign only_i    = sample.inner_detect && !sample.outer_detect;
   assign both      = sample.outer_detect && sample.inner_detect;
   assign none      = !sample.outer_detect && !sample.inner_detect;
   assign room_left = (count_ff < capacity_ff) && ({8'd0, count_ff} < COUNT_MAX);

   always_comb begin
      seq_in   = seq_ff;
      count_in = count_ff;
      pass_ev  = PASS_NONE;
      err      = ERR_NONE;
      if (sample.restart) begin
         seq_in = SQ_IDLE;
      end else begin
         case (seq_ff)
            SQ_IN_START: begin
               if (both) seq_in = SQ_IN_BOTH;
               else if (none) seq_in = SQ_IDLE;
               else if (only_i) begin
                  err    = ERR_ENTRY_ORDER;
                  seq_in = SQ_IDLE;
               end
            end
            SQ_IN_BOTH: begin
               if (only_i) seq_in = SQ_IN_INNER;
               else if (only_o) seq_in = SQ_IN_START;
               else if (none) begin
                  err    = ERR_ENTRY_ORDER;
                  seq_in = SQ_IDLE;
               end
            end
            SQ_IN_INNER: begin
               if (none) seq_in = SQ_IN_DONE;
               else if (both) seq_in = SQ_IN_BOTH;
               else if (only_o) begin
                  err    = ERR_ENTRY_ORDER;
                  seq_in = SQ_IDLE;
               end
            end
            SQ_IN_DONE: begin
               if (room_left) begin
                  count_in = count_ff + 8'd1;
                  pass_ev  = PASS_ENTER;
               end else begin
                  err = ERR_FULL;
               end
               seq_in = SQ_IDLE;
            end
            SQ_OUT_START: begin
               if (both) seq_in = SQ_OUT_BOTH;
               else if (none) seq_in = SQ_IDLE;
               else if (only_o) begin
                  err    = ERR_EXIT_ORDER;
                  seq_in = SQ_IDLE;
               end
            end
            SQ_OUT_BOTH: begin
               if (only_o) seq_in = SQ_OUT_OUTER;
               else if (only_i) seq_in = SQ_OUT_START;
               else if (none) begin
                  err    = ERR_EXIT_ORDER;
                  seq_in = SQ_IDLE;
               end
            end
            SQ_OUT_OUTER: begin
               if (none) seq_in = SQ_OUT_DONE;
               else if (both) seq_in = SQ_OUT_BOTH;
               else if (only_i) begin
                  err    = ERR_EXIT_ORDER;
                  seq_in = SQ_IDLE;
               end
            end
            SQ_OUT_DONE: begin
               if (count_ff != 8'd0) begin
                  count_in = count_ff - 8'd1;
                  pass_ev  = PASS_LEAVE;
               end else begin
                  err = ERR_EMPTY;
               end
               seq_in = SQ_IDLE;
            end
            default: begin
               if (only_o) seq_in = SQ_IN_START;
               else if (only_i) seq_in = SQ_OUT_START;
               else seq_in = SQ_IDLE;
            end
         endcase
      end

      full_in = full_ff;
      load_ev = LOAD_NONE;
      if (!full_ff && (count_in >= capacity_ff)) begin
         full_in = 1'b1;
         load_ev = LOAD_FULL;
      end else if (full_ff && (count_in < capacity_ff)) begin
         full_in = 1'b0;
         load_ev = LOAD_NOT_FULL;
      end
   end

   assign result.occupancy     = count_in;
   assign result.pass_event    = pass_ev;
   assign result.error_code    = err;
   assign result.load_event    = load_ev;
   assign result.entry_allowed = !full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= SQ_IDLE;
         count_ff <= 8'd0;
         full_ff  <= 1'b0;
      end else if (step) begin
         seq_ff   <= seq_in;
         count_ff <= count_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

endmodule

FILE: src/occ_out_stage.sv
// ----------------------------------------------------------------------------
// Occupancy counter output stage
// Result register that holds a response transaction while the receiver stalls.
// ----------------------------------------------------------------------------
module occ_out_stage
   import occ_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        up_valid,
   input  occ_rsp_type up_data,
   output logic        up_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output occ_rsp_type rsp_data
);

   logic        valid_ff;
   occ_rsp_type data_ff;

   assign up_ready  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= up_data;
      end
   end

endmodule

FILE: src/bidirectional_occupancy_counter.sv
// ----------------------------------------------------------------------------
// Bidirectional occupancy counter
// Counts persons passing a doorway watched by an outer and an inner detector.
//
// Each request transaction carries one detector sample and a restart bit and
// produces exactly one response transaction with the occupancy, pass event,
// error code, load event and entry-allowed level. The room capacity register
// is written through csr_wr_en and csr_wr_data; the user must write it only
// while no transaction is open, and the block itself does not enforce this.
// A request is captured in an input register; the sequence tracker then
// updates its state as the response is written into the result register,
// which drives rsp_valid. One request is accepted every cycle while req_stall
// is low. When rsp_stall is high the result register holds, the input
// register keeps at most one more request, and req_stall is raised while it
// is occupied. Reset clears the valid bits of both registers, returns the
// tracker to idle with a count of zero and not full, and sets capacity to 255.
// ----------------------------------------------------------------------------
module bidirectional_occupancy_counter
   import occ_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  occ_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output occ_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic        stage_valid;
   occ_req_type stage_data;
   logic        down_ready;
   occ_rsp_type result;

   occ_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .down_ready  (down_ready)
   );

   occ_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (stage_valid && down_ready),
      .sample      (stage_data),
      .result      (result)
   );

   occ_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (stage_valid),
      .up_data   (result),
      .up_ready  (down_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/occ_checker.sv
// ----------------------------------------------------------------------------
// Occupancy counter checker
// Port-level assertions on the occupancy counter, attached by a bind.
// ----------------------------------------------------------------------------
module occ_checker
   import occ_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input occ_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input occ_rsp_type rsp_data
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_pass_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.pass_event != PASS_NONE) |->
      rsp_data.error_code == ERR_NONE)
      else $error("pass event with an error");

   a_load_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.load_event != LOAD_NONE) |->
      rsp_data.entry_allowed == (rsp_data.load_event == LOAD_NOT_FULL))
      else $error("load event disagrees with entry level");

endmodule

bind bidirectional_occupancy_counter occ_checker u_occ_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_data    (req_data),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Occupancy counter testbench
// Sends detector samples through the request channel. Most are whole entry
// and exit walks with random repeats and step-backs; the rest are broken walks
// and noise. A predictor of the doorway tracker, the count and the full flag
// builds one report per accepted sample, and each returned report is checked
// field by field. The capacity is changed between phases while the block is
// idle. Both channels idle at random, except in the last phase.
// ----------------------------------------------------------------------------
module testbench
   import occ_pkg::*;
;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_AT = 400;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   occ_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   occ_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;

   occ_req_type detector_samples[$];
   occ_rsp_type predicted_reports[$];
   occ_rsp_type want_report;

   logic [3:0] door_state = SQ_IDLE;
   logic [7:0] head_count = 8'd0;
   logic       room_full = 1'b0;
   logic [7:0] room_limit = CAPACITY_RESET;

   int  samples_queued = 0;
   int  reports_seen = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  long_hold_done = 1'b0;
   bit  steady_finish = 1'b0;

   bidirectional_occupancy_counter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic occ_rsp_type advance_doorway(occ_req_type smp);
      occ_rsp_type rpt;
      logic        only_o;
      logic        only_i;
      logic        both;
      logic        none;
      logic [3:0]  nxt;
      only_o = smp.outer_detect & ~smp.inner_detect;
      only_i = smp.inner_detect & ~smp.outer_detect;
      both = smp.outer_detect & smp.inner_detect;
      none = ~smp.outer_detect & ~smp.inner_detect;
      rpt = '0;
      rpt.pass_event = PASS_NONE;
      rpt.error_code = ERR_NONE;
      rpt.load_event = LOAD_NONE;
      nxt = door_state;
      if (smp.restart) begin
         nxt = SQ_IDLE;
      end else begin
         case (door_state)
            SQ_IN_START: begin
               if (both) nxt = SQ_IN_BOTH;
               else if (none) nxt = SQ_IDLE;
               else if (only_i) begin
                  rpt.error_code = ERR_ENTRY_ORDER;
                  nxt = SQ_IDLE;
               end
            end
            SQ_IN_BOTH: begin
               if (only_i) nxt = SQ_IN_INNER;
               else if (only_o) nxt = SQ_IN_START;
               else if (none) begin
                  rpt.error_code = ERR_ENTRY_ORDER;
                  nxt = SQ_IDLE;
               end
            end
            SQ_IN_INNER: begin
               if (none) nxt = SQ_IN_DONE;
               else if (both) nxt = SQ_IN_BOTH;
               else if (only_o) begin
                  rpt.error_code = ERR_ENTRY_ORDER;
                  nxt = SQ_IDLE;
               end
            end
            SQ_IN_DONE: begin
               if (head_count < room_limit && {8'd0, head_count} < COUNT_MAX) begin
                  head_count = head_count + 8'd1;
                  rpt.pass_event = PASS_ENTER;
               end else begin
                  rpt.error_code = ERR_FULL;
               end
               nxt = SQ_IDLE;
            end
            SQ_OUT_START: begin
               if (both) nxt = SQ_OUT_BOTH;
               else if (none) nxt = SQ_IDLE;
               else if (only_o) begin
                  rpt.error_code = ERR_EXIT_ORDER;
                  nxt = SQ_IDLE;
               end
            end
            SQ_OUT_BOTH: begin
               if (only_o) nxt = SQ_OUT_OUTER;
               else if (only_i) nxt = SQ_OUT_START;
               else if (none) begin
                  rpt.error_code = ERR_EXIT_ORDER;
                  nxt = SQ_IDLE;
               end
            end
            SQ_OUT_OUTER: begin
               if (none) nxt = SQ_OUT_DONE;
               else if (both) nxt = SQ_OUT_BOTH;
               else if (only_i) begin
                  rpt.error_code = ERR_EXIT_ORDER;
                  nxt = SQ_IDLE;
               end
            end
            SQ_OUT_DONE: begin
               if (head_count != 8'd0) begin
                  head_count = head_count - 8'd1;
                  rpt.pass_event = PASS_LEAVE;
               end else begin
                  rpt.error_code = ERR_EMPTY;
               end
               nxt = SQ_IDLE;
            end
            default: begin
               if (only_o) nxt = SQ_IN_START;
               else if (only_i) nxt = SQ_OUT_START;
               else nxt = SQ_IDLE;
            end
         endcase
      end
      door_state = nxt;
      if (!room_full && head_count >= room_limit) begin
         room_full = 1'b1;
         rpt.load_event = LOAD_FULL;
      end else if (room_full && head_count < room_limit) begin
         room_full = 1'b0;
         rpt.load_event = LOAD_NOT_FULL;
      end
      rpt.occupancy = head_count;
      rpt.entry_allowed = ~room_full;
      return rpt;
   endfunction

   task automatic compare_field(string field, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      end
   endtask

   // Pattern bits are {outer, inner}.
   task automatic queue_pattern(logic [1:0] det, logic rst);
      occ_req_type smp;
      smp.outer_detect = det[1];
      smp.inner_detect = det[0];
      smp.restart = rst;
      detector_samples.push_back(smp);
      samples_queued++;
   endtask

   task automatic queue_passage(bit entering);
      logic [1:0] first_p;
      logic [1:0] last_p;
      first_p = entering ? 2'b10 : 2'b01;
      last_p = entering ? 2'b01 : 2'b10;
      queue_pattern(first_p, 1'b0);
      repeat ($urandom_range(0, 2)) queue_pattern(first_p, 1'b0);
      queue_pattern(2'b11, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         queue_pattern(first_p, 1'b0);
         queue_pattern(2'b11, 1'b0);
      end
      queue_pattern(last_p, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         queue_pattern(2'b11, 1'b0);
         queue_pattern(last_p, 1'b0);
      end
      queue_pattern(2'b00, 1'b0);
      // The sample on the completion tick is ignored; a restart drops the count change.
      queue_pattern(2'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
   endtask

   task automatic queue_broken_passage(bit entering);
      logic [1:0] first_p;
      first_p = entering ? 2'b10 : 2'b01;
      queue_pattern(first_p, 1'b0);
      if ($urandom_range(0, 1) == 0) queue_pattern(2'b11, 1'b0);
      if ($urandom_range(0, 1) == 0) queue_pattern(entering ? 2'b01 : 2'b10, 1'b0);
      queue_pattern(2'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
   endtask

   task automatic queue_traffic(int count);
      int target;
      int pick;
      target = samples_queued + count;
      while (samples_queued < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) queue_passage(1'($urandom_range(0, 1)));
         else if (pick < 9) queue_pattern(2'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
         else queue_broken_passage(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (detector_samples.size() != 0 || req_valid || predicted_reports.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_capacity(logic [7:0] value);
      wait_until_drained();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      room_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) predicted_reports.push_back(advance_doorway(req_data));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!steady_finish && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (detector_samples.size() != 0) begin
               req_data <= detector_samples.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            reports_seen++;
            if (predicted_reports.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transaction, expected none, actual %p", $time, rsp_data);
            end else begin
               want_report = predicted_reports.pop_front();
               compare_field("occupancy", want_report.occupancy, rsp_data.occupancy);
               compare_field("pass_event", 8'(want_report.pass_event),
                             8'(rsp_data.pass_event));
               compare_field("error_code", 8'(want_report.error_code),
                             8'(rsp_data.error_code));
               compare_field("load_event", 8'(want_report.load_event),
                             8'(rsp_data.load_event));
               compare_field("entry_allowed", 8'(want_report.entry_allowed),
                             8'(rsp_data.entry_allowed));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && reports_seen >= LONG_HOLD_AT) begin
            // A long hold-off lets the block fill up and stall its input.
            long_hold_done = 1'b1;
            stall_left = 60;
            rsp_stall <= 1'b1;
         end else if (!steady_finish && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity.
      queue_pattern(2'b00, 1'b0);
      queue_pattern(2'b01, 1'b0);
      queue_pattern(2'b11, 1'b0);
      queue_pattern(2'b10, 1'b0);
      queue_pattern(2'b00, 1'b0);
      queue_pattern(2'b11, 1'b0);
      queue_pattern(2'b10, 1'b0);
      queue_pattern(2'b10, 1'b0);
      queue_pattern(2'b11, 1'b0);
      queue_pattern(2'b10, 1'b0);
      queue_pattern(2'b11, 1'b0);
      queue_pattern(2'b01, 1'b0);
      queue_pattern(2'b11, 1'b0);
      queue_pattern(2'b01, 1'b0);
      queue_pattern(2'b00, 1'b0);
      queue_pattern(2'b00, 1'b0);
      queue_pattern(2'b10, 1'b0);
      queue_pattern(2'b01, 1'b0);
      queue_pattern(2'b01, 1'b0);
      queue_pattern(2'b10, 1'b0);
      queue_pattern(2'b01, 1'b0);
      queue_pattern(2'b11, 1'b0);
      queue_pattern(2'b01, 1'b0);
      queue_pattern(2'b11, 1'b1);
      queue_pattern(2'b00, 1'b0);

      write_capacity(8'd0);
      queue_traffic(150);
      write_capacity(8'd255);
      queue_traffic(300);
      write_capacity(8'd1);
      queue_traffic(200);
      write_capacity(8'd2);
      queue_traffic(200);
      write_capacity(8'($urandom_range(3, 8)));
      queue_traffic(300);
      write_capacity(8'($urandom_range(0, 255)));
      queue_traffic(150);
      wait_until_drained();
      steady_finish = 1'b1;
      write_capacity(8'd3);
      queue_traffic(200);

      wait_until_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: bidirectional_occupancy_counter.f
src/occ_pkg.sv
src/occ_in_stage.sv
src/occ_tracker.sv
src/occ_out_stage.sv
src/bidirectional_occupancy_counter.sv
src/occ_checker.sv
bench/testbench.sv
